FILE: src/hcd_pkg.sv
// Shared types, constants and helpers for the HTTP chunked body decoder.
package hcd_pkg;

  localparam int unsigned SIZE_BITS = 32;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_CR  = 8'h0d;

  typedef enum logic [2:0] {
    ST_FRAME = 3'd0,
    ST_DATA  = 3'd1,
    ST_HEAD  = 3'd2,
    ST_END   = 3'd3,
    ST_ERR   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    HALT_RUN   = 2'd0,
    HALT_ENDED = 2'd1,
    HALT_ERROR = 2'd2
  } halt_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  data;
    logic        chunk_end;
    logic [31:0] chunk_length;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.is_hex = 1'b0;
    d.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.is_hex = 1'b1;
      d.value  = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.is_hex = 1'b1;
      d.value  = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.is_hex = 1'b1;
      d.value  = 4'(c - 8'h37);
    end
    return d;
  endfunction

endpackage

FILE: src/http_chunked_decoder_top.sv
// HTTP chunked body decoder: header parse, data pass-through, output skid stage.
// Each accepted byte's result is registered in the output register, or in the skid register
// while the output stalls. Throughput: one byte per cycle while in_stall is low; the state
// update is combinational, and a skid register absorbs one stall.
// Reset (rst_n low, synchronous): header mode, size and count cleared, running,
// output and skid registers empty.
module http_chunked_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_byte,
  output logic        out_chunk_end,
  output logic [31:0] out_chunk_length
);

  localparam int unsigned SB = hcd_pkg::SIZE_BITS;

  logic               in_data_r,  in_data_nxt;
  logic [SB-1:0]      size_r,     size_nxt;
  logic [SB-1:0]      left_r,     left_nxt;
  logic               stopped_r,  stopped_nxt;
  logic               content_r,  content_nxt;
  logic               pend_cr_r,  pend_cr_nxt;
  hcd_pkg::halt_t     halt_r,     halt_nxt;

  hcd_pkg::result_t   res;
  hcd_pkg::result_t   out_r,      out_nxt;
  hcd_pkg::result_t   skid_r,     skid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;

  logic               in_acc;
  logic               out_take;
  logic [SB-1:0]      left_dec;
  hcd_pkg::hex_digit_t dig;
  logic               stop_mid;

  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  assign left_dec = left_r - SB'(1);
  assign dig      = hcd_pkg::hex_decode(in_byte);

  // per-byte decode
  always_comb begin
    in_data_nxt = in_data_r;
    size_nxt    = size_r;
    left_nxt    = left_r;
    stopped_nxt = stopped_r;
    content_nxt = content_r;
    pend_cr_nxt = pend_cr_r;
    halt_nxt    = halt_r;
    stop_mid    = stopped_r;
    res.status       = hcd_pkg::ST_FRAME;
    res.data         = 8'd0;
    res.chunk_end    = 1'b0;
    res.chunk_length = 32'd0;
    priority if (halt_r != hcd_pkg::HALT_RUN) begin
      halt_nxt   = hcd_pkg::HALT_ERROR;
      res.status = hcd_pkg::ST_ERR;
    end else if (in_data_r) begin
      left_nxt   = left_dec;
      res.status = hcd_pkg::ST_DATA;
      res.data   = in_byte;
      if (left_dec == '0) begin
        res.chunk_end = 1'b1;
        in_data_nxt   = 1'b0;
      end
    end else if (in_byte == hcd_pkg::CHAR_NUL) begin
      halt_nxt   = hcd_pkg::HALT_ERROR;
      res.status = hcd_pkg::ST_ERR;
    end else if (in_byte == hcd_pkg::CHAR_LF) begin
      priority if (!content_r) begin
        left_nxt   = '0;
        res.status = hcd_pkg::ST_FRAME;
      end else if (size_r == '0) begin
        halt_nxt   = hcd_pkg::HALT_ENDED;
        res.status = hcd_pkg::ST_END;
      end else begin
        left_nxt         = size_r;
        in_data_nxt      = 1'b1;
        res.status       = hcd_pkg::ST_HEAD;
        res.chunk_length = 32'(size_r);
      end
      size_nxt    = '0;
      stopped_nxt = 1'b0;
      content_nxt = 1'b0;
      pend_cr_nxt = 1'b0;
    end else begin
      // a held CR turns out to be line content and ends the hex digits
      if (pend_cr_r) begin
        content_nxt = 1'b1;
        stop_mid    = 1'b1;
      end
      stopped_nxt = stop_mid;
      if (in_byte == hcd_pkg::CHAR_CR) begin
        pend_cr_nxt = 1'b1;
      end else begin
        pend_cr_nxt = 1'b0;
        content_nxt = 1'b1;
        if (!stop_mid) begin
          if (dig.is_hex) begin
            size_nxt = {size_r[SB-5:0], dig.value};
          end else begin
            stopped_nxt = 1'b1;
          end
        end
      end
    end
  end

  // output register with one skid entry
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (in_acc) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_data_r    <= 1'b0;
      size_r       <= '0;
      left_r       <= '0;
      stopped_r    <= 1'b0;
      content_r    <= 1'b0;
      pend_cr_r    <= 1'b0;
      halt_r       <= hcd_pkg::HALT_RUN;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_data_r <= in_data_nxt;
        size_r    <= size_nxt;
        left_r    <= left_nxt;
        stopped_r <= stopped_nxt;
        content_r <= content_nxt;
        pend_cr_r <= pend_cr_nxt;
        halt_r    <= halt_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_byte         = out_r.data;
  assign out_chunk_end    = out_r.chunk_end;
  assign out_chunk_length = out_r.chunk_length;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_data_running: assert property (@(posedge clk) disable iff (!rst_n)
    in_data_r |-> (halt_r == hcd_pkg::HALT_RUN))
    else $error("data mode while halted");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_data_r |-> (left_r != '0))
    else $error("data mode with zero bytes left");

  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data_r && left_r == SB'(1)) |=> !in_data_r)
    else $error("data mode kept after last byte of chunk");

  a_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chunk_end) |-> (out_r.status == hcd_pkg::ST_DATA))
    else $error("chunk end mark on a non-data beat");

endmodule

FILE: tb/http_chunked_decoder_top_tb.sv
// Testbench for the HTTP chunked body decoder: scripted and random byte streams checked per beat.
module http_chunked_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_t;
  typedef enum int {END_ZERO, END_ZERO_EXT, END_NO_DIGITS, END_EXTRA_CR, END_NUL} ending_t;

  localparam logic [hcd_pkg::SIZE_BITS-1:0] LEFT_STEP = 1;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_byte;
  logic        out_chunk_end;
  logic [31:0] out_chunk_length;

  // decoder state as predicted from the accepted bytes
  logic                          in_chunk = 1'b0;
  logic [hcd_pkg::SIZE_BITS-1:0] size_acc = '0;
  logic [hcd_pkg::SIZE_BITS-1:0] left_in_chunk = '0;
  logic                          digits_done = 1'b0;
  logic                          line_busy = 1'b0;
  logic                          cr_held = 1'b0;
  hcd_pkg::halt_t                halt = hcd_pkg::HALT_RUN;

  hcd_pkg::result_t decoded_q[$];
  hcd_pkg::result_t want;
  int               mismatch_count = 0;
  int               bytes_sent = 0;
  int               burst_left = 0;
  int               stall_span = 0;
  stall_mode_t      stall_mode = STALL_NONE;

  http_chunked_decoder_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_byte         (out_byte),
    .out_chunk_end    (out_chunk_end),
    .out_chunk_length (out_chunk_length)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void take_line_char(input logic [7:0] c);
    int v;
    line_busy = 1'b1;
    if (!digits_done) begin
      v = hex_nibble(c);
      if (v < 0) digits_done = 1'b1;
      else size_acc = {size_acc[hcd_pkg::SIZE_BITS-5:0], 4'(v)};
    end
  endfunction

  function automatic hcd_pkg::result_t decode_byte(input logic [7:0] c);
    hcd_pkg::result_t r;
    r.status       = hcd_pkg::ST_FRAME;
    r.data         = 8'h00;
    r.chunk_end    = 1'b0;
    r.chunk_length = 32'h0;
    if (halt != hcd_pkg::HALT_RUN) begin
      halt     = hcd_pkg::HALT_ERROR;
      r.status = hcd_pkg::ST_ERR;
    end else if (in_chunk) begin
      left_in_chunk = left_in_chunk - LEFT_STEP;
      r.status      = hcd_pkg::ST_DATA;
      r.data        = c;
      if (left_in_chunk == '0) begin
        r.chunk_end = 1'b1;
        in_chunk    = 1'b0;
      end
    end else if (c == hcd_pkg::CHAR_NUL) begin
      halt     = hcd_pkg::HALT_ERROR;
      r.status = hcd_pkg::ST_ERR;
    end else if (c == hcd_pkg::CHAR_LF) begin
      // an empty line is the tail after chunk data
      if (!line_busy) begin
        left_in_chunk = '0;
      end else if (size_acc == '0) begin
        halt     = hcd_pkg::HALT_ENDED;
        r.status = hcd_pkg::ST_END;
      end else begin
        left_in_chunk  = size_acc;
        in_chunk       = 1'b1;
        r.status       = hcd_pkg::ST_HEAD;
        r.chunk_length = size_acc[31:0];
      end
      size_acc    = '0;
      digits_done = 1'b0;
      line_busy   = 1'b0;
      cr_held     = 1'b0;
    end else begin
      // hold a CR until we know whether it ends the line
      if (cr_held) take_line_char(hcd_pkg::CHAR_CR);
      cr_held = (c == hcd_pkg::CHAR_CR);
      if (c != hcd_pkg::CHAR_CR) take_line_char(c);
    end
    return r;
  endfunction

  task automatic report_field(input string field, input logic [31:0] exp_val, got_val);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, exp_val, got_val);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) decoded_q.push_back(decode_byte(in_byte));
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual status %0d byte 0x%0h",
                   $time, out_status, out_byte);
          mismatch_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_status !== 3'(want.status))
            report_field("status", 32'(want.status), 32'(out_status));
          if (out_byte !== want.data)
            report_field("out_byte", 32'(want.data), 32'(out_byte));
          if (out_chunk_end !== want.chunk_end)
            report_field("chunk_end", 32'(want.chunk_end), 32'(out_chunk_end));
          if (out_chunk_length !== want.chunk_length)
            report_field("chunk_length", want.chunk_length, out_chunk_length);
        end
      end
    end
  end

  // receiver back-pressure: switch among four stall patterns, each held for a random span
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(20, 200);
    end
    stall_span--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_span[1];
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(hcd_pkg::CHAR_CR);
    send_byte(hcd_pkg::CHAR_LF);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return "0" + 8'(v);
    return (upper ? "A" : "a") + 8'(v) - 8'd10;
  endfunction

  // chunk header with random case, padding, wrap-around prefix and extension
  task automatic send_header(input logic [31:0] size);
    int ndig;
    bit upper;
    logic [7:0] c;
    ndig  = 1;
    upper = 1'($urandom_range(0, 1));
    while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
    case ($urandom_range(0, 7))
      0: begin
        // extra high digits fall off the 32-bit size
        repeat ($urandom_range(1, 3)) send_byte(hex_char(4'($urandom_range(0, 15)), upper));
        ndig = 8;
      end
      1: repeat ($urandom_range(1, 2)) send_byte("0");
      default: ;
    endcase
    for (int i = ndig - 1; i >= 0; i--) send_byte(hex_char(size[4*i +: 4], upper));
    if ($urandom_range(0, 3) == 0) begin
      do c = 8'($urandom_range(1, 255)); while (hex_nibble(c) >= 0 || c == hcd_pkg::CHAR_LF);
      send_byte(c);
      repeat ($urandom_range(0, 5)) begin
        do c = 8'($urandom_range(1, 255)); while (c == hcd_pkg::CHAR_LF);
        send_byte(c);
      end
    end
    if ($urandom_range(0, 3) != 0) send_byte(hcd_pkg::CHAR_CR);
    send_byte(hcd_pkg::CHAR_LF);
  endtask

  task automatic test_tail_lines();
    send_byte(hcd_pkg::CHAR_LF);
    send_crlf();
  endtask

  task automatic test_data_extremes();
    send_text("4");
    send_byte(hcd_pkg::CHAR_LF);
    send_byte(hcd_pkg::CHAR_NUL);
    send_byte(8'hff);
    send_byte(hcd_pkg::CHAR_LF);
    send_byte(hcd_pkg::CHAR_CR);
    send_crlf();
  endtask

  task automatic test_cr_in_header();
    // a CR followed by another CR is line content and stops the digits
    send_text("1");
    send_byte(hcd_pkg::CHAR_CR);
    send_crlf();
    send_byte(8'h5a);
    send_byte(hcd_pkg::CHAR_LF);
    // digits after a mid-line CR are ignored; no tail line after the data
    send_text("1");
    send_byte(hcd_pkg::CHAR_CR);
    send_text("A");
    send_byte(hcd_pkg::CHAR_LF);
    send_byte(8'h01);
  endtask

  task automatic test_size_wrap();
    send_text("F00000001");
    send_byte(hcd_pkg::CHAR_LF);
    send_byte(8'h80);
    send_crlf();
  endtask

  task automatic test_random_chunks();
    int stop_at;
    logic [31:0] size;
    stop_at = bytes_sent + 1800;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 15))
        0:       size = $urandom_range(65, 300);
        1, 2, 3: size = $urandom_range(17, 64);
        default: size = $urandom_range(1, 16);
      endcase
      send_header(size);
      repeat (size) send_byte(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 7))
        0:       send_byte(hcd_pkg::CHAR_LF);
        1:       ;
        default: send_crlf();
      endcase
      // stray empty lines between chunks
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) != 0) send_byte(hcd_pkg::CHAR_CR);
        send_byte(hcd_pkg::CHAR_LF);
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  task automatic test_end_of_body();
    case (ending_t'($urandom_range(0, 4)))
      END_ZERO: begin
        send_text("0");
        send_crlf();
      end
      END_ZERO_EXT: begin
        send_text("000;last");
        send_byte(hcd_pkg::CHAR_LF);
      end
      END_NO_DIGITS: begin
        send_text("x1");
        send_crlf();
      end
      END_EXTRA_CR: begin
        send_byte(hcd_pkg::CHAR_CR);
        send_crlf();
      end
      default: begin
        send_text("5");
        send_byte(hcd_pkg::CHAR_NUL);
      end
    endcase
    // everything after the end or an error must stay an error
    send_byte(hcd_pkg::CHAR_NUL);
    repeat ($urandom_range(3, 8)) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int waited;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_tail_lines();
    test_data_extremes();
    wait_drained();
    test_cr_in_header();
    test_size_wrap();
    wait_drained();
    test_random_chunks();
    wait_drained();
    test_end_of_body();
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (decoded_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (decoded_q.size() != 0) begin
      $display("%0t: %0d results missing, expected status %0d first, actual none", $time,
               decoded_q.size(), decoded_q[0].status);
      mismatch_count++;
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("http_chunked_decoder_top_tb OK");
    end else begin
      $display("http_chunked_decoder_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("http_chunked_decoder_top_tb NOT OK");
    $finish;
  end

endmodule
